// ----- rtl/ehc_pkg.sv -----
// Shared types, constants and flag helpers for the encryption header checker.
package ehc_pkg;

    // Word positions within the header
    localparam logic [3:0] POS_VERSION   = 4'd0;
    localparam logic [3:0] POS_FLAGS     = 4'd1;
    localparam logic [3:0] POS_HDR_SIZE  = 4'd2;
    localparam logic [3:0] POS_FLAGS_CPY = 4'd3;
    localparam logic [3:0] POS_EXTRA     = 4'd4;
    localparam logic [3:0] POS_ALG_ID    = 4'd5;
    localparam logic [3:0] POS_HASH_ID   = 4'd6;
    localparam logic [3:0] POS_KEY_SIZE  = 4'd7;
    localparam logic [3:0] POS_PROVIDER  = 4'd8;
    localparam logic [3:0] POS_RESERVED1 = 4'd9;
    localparam logic [3:0] POS_RESERVED2 = 4'd10;

    // Verdict codes
    localparam logic [2:0] ST_STD_OK      = 3'd0;
    localparam logic [2:0] ST_AGILE_OK    = 3'd1;
    localparam logic [2:0] ST_RC4         = 3'd2;
    localparam logic [2:0] ST_RC4_API     = 3'd3;
    localparam logic [2:0] ST_EXT         = 3'd4;
    localparam logic [2:0] ST_BAD_VERSION = 3'd5;
    localparam logic [2:0] ST_BAD_FLAGS   = 3'd6;
    localparam logic [2:0] ST_BAD_FIELD   = 3'd7;

    // Path kinds
    localparam logic [1:0] PATH_STD   = 2'd0;
    localparam logic [1:0] PATH_RC4   = 2'd1;
    localparam logic [1:0] PATH_EXT   = 2'd2;
    localparam logic [1:0] PATH_AGILE = 2'd3;

    // Algorithm codes
    localparam logic [2:0] ALG_NONE   = 3'd0;
    localparam logic [2:0] ALG_RC4    = 3'd1;
    localparam logic [2:0] ALG_AES128 = 3'd2;
    localparam logic [2:0] ALG_AES192 = 3'd3;
    localparam logic [2:0] ALG_AES256 = 3'd4;

    // Flag bits
    localparam logic [31:0] FLAG_RSVD_MASK = 32'h0000_0003;
    localparam logic [31:0] FLAG_C         = 32'h0000_0004;
    localparam logic [31:0] FLAG_D         = 32'h0000_0008;
    localparam logic [31:0] FLAG_E         = 32'h0000_0010;
    localparam logic [31:0] FLAG_F         = 32'h0000_0020;

    // Field values
    localparam logic [31:0] ALGID_RC4    = 32'h0000_6801;
    localparam logic [31:0] ALGID_AES128 = 32'h0000_660E;
    localparam logic [31:0] ALGID_AES192 = 32'h0000_660F;
    localparam logic [31:0] ALGID_AES256 = 32'h0000_6610;
    localparam logic [31:0] HASHID_SHA1  = 32'h0000_8004;
    localparam logic [31:0] AGILE_FLAGS  = 32'h0000_0040;
    localparam logic [31:0] RC4_KEY_MIN  = 32'h0000_0028;
    localparam logic [31:0] RC4_KEY_MAX  = 32'h0000_0080;
    localparam logic [8:0]  AES128_BITS  = 9'h080;
    localparam logic [8:0]  AES192_BITS  = 9'h0C0;
    localparam logic [8:0]  AES256_BITS  = 9'h100;

    typedef struct packed {
        logic [3:0]  word_position;
        logic [1:0]  path_kind;
        logic [31:0] saved_flags;
        logic [2:0]  algorithm_code;
        logic [8:0]  saved_aes_key_len;
        logic        verdict_given;
    } hdr_state_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] fail_index;
        logic [8:0] aes_key_len;
    } verdict_t;

    localparam hdr_state_t STATE_IDLE = '{
        word_position:     4'd0,
        path_kind:         PATH_STD,
        saved_flags:       32'd0,
        algorithm_code:    ALG_NONE,
        saved_aes_key_len: 9'd0,
        verdict_given:     1'b1
    };

    function automatic logic generic_flags_ok(input logic [31:0] f);
        logic c;
        logic e;
        logic ok;
        c  = |(f & FLAG_C);
        e  = |(f & FLAG_E);
        ok = 1'b1;
        if (|(f & FLAG_RSVD_MASK)) ok = 1'b0;
        if (c == e) ok = 1'b0;
        if (e && |(f & (FLAG_C | FLAG_D | FLAG_F))) ok = 1'b0;
        if (|(f & FLAG_F) && !c) ok = 1'b0;
        return ok;
    endfunction

    function automatic logic [8:0] aes_bits_for(input logic [2:0] code);
        logic [8:0] bits;
        case (code)
            ALG_AES128: bits = AES128_BITS;
            ALG_AES192: bits = AES192_BITS;
            ALG_AES256: bits = AES256_BITS;
            default:    bits = 9'd0;
        endcase
        return bits;
    endfunction

endpackage

// ----- rtl/ehc_word_check.sv -----
// Per-word header rules: next header state and the verdict a word may decide.
module ehc_word_check (
    input  ehc_pkg::hdr_state_t state,
    input  logic [31:0]         word,
    input  logic                start_req,
    output ehc_pkg::hdr_state_t state_next,
    output logic                emit,
    output ehc_pkg::verdict_t   verdict
);
    import ehc_pkg::*;

    always_comb begin
        hdr_state_t cur;
        hdr_state_t nxt;
        logic [15:0] major;
        logic [15:0] minor;
        logic [2:0]  code;
        logic [8:0]  aes;
        logic        code_ok;
        logic        ok;
        logic        c;
        logic        e;
        logic        f;

        cur = state;
        if (start_req) begin
            cur = STATE_IDLE;
            cur.verdict_given = 1'b0;
        end
        nxt     = cur;
        emit    = 1'b0;
        verdict = '{status: ST_BAD_FIELD, fail_index: cur.word_position, aes_key_len: 9'd0};
        major   = word[15:0];
        minor   = word[31:16];
        c       = |(cur.saved_flags & FLAG_C);
        e       = |(cur.saved_flags & FLAG_E);
        f       = |(cur.saved_flags & FLAG_F);
        code    = ALG_NONE;
        code_ok = 1'b1;
        aes     = aes_bits_for(cur.algorithm_code);
        ok      = 1'b1;

        if (!cur.verdict_given) begin
            nxt.word_position = cur.word_position + 4'd1;
            case (cur.word_position)
                POS_VERSION: begin
                    if (major == 16'd1 && minor == 16'd1) begin
                        emit = 1'b1;
                        verdict.status = ST_RC4;
                    end else if (major inside {[16'd2:16'd4]} && minor == 16'd2) begin
                        nxt.path_kind = PATH_STD;
                    end else if ((major == 16'd3 || major == 16'd4) && minor == 16'd3) begin
                        nxt.path_kind = PATH_EXT;
                    end else if (major == 16'd4 && minor == 16'd4) begin
                        nxt.path_kind = PATH_AGILE;
                    end else begin
                        emit = 1'b1;
                        verdict.status = ST_BAD_VERSION;
                    end
                end
                POS_FLAGS: begin
                    nxt.saved_flags = word;
                    if (cur.path_kind == PATH_AGILE) begin
                        emit = 1'b1;
                        verdict.status = (word == AGILE_FLAGS) ? ST_AGILE_OK : ST_BAD_FIELD;
                    end else if (!generic_flags_ok(word)) begin
                        emit = 1'b1;
                        verdict.status = ST_BAD_FLAGS;
                    end else if (cur.path_kind == PATH_EXT) begin
                        if (!(|(word & FLAG_E))) begin
                            emit = 1'b1;
                            verdict.status = ST_BAD_FLAGS;
                        end
                    end else if (|(word & FLAG_E)) begin
                        emit = 1'b1;
                        verdict.status = ST_BAD_FLAGS;
                    end else if (|(word & FLAG_F)) begin
                        if (|(word & FLAG_D)) begin
                            emit = 1'b1;
                            verdict.status = ST_BAD_FLAGS;
                        end else begin
                            nxt.path_kind = PATH_STD;
                        end
                    end else begin
                        nxt.path_kind = PATH_RC4;
                    end
                end
                POS_FLAGS_CPY: begin
                    if (!generic_flags_ok(word) || word != cur.saved_flags) begin
                        emit = 1'b1;
                        verdict.status = ST_BAD_FLAGS;
                    end
                end
                POS_EXTRA: begin
                    emit = (word != 32'd0);
                end
                POS_ALG_ID: begin
                    if (word == 32'd0) code = ALG_NONE;
                    else if (word == ALGID_RC4) code = ALG_RC4;
                    else if (word == ALGID_AES128) code = ALG_AES128;
                    else if (word == ALGID_AES192) code = ALG_AES192;
                    else if (word == ALGID_AES256) code = ALG_AES256;
                    else code_ok = 1'b0;
                    if (e) ok = (code == ALG_NONE);
                    else if (f) ok = (code == ALG_NONE) || (code >= ALG_AES128);
                    else ok = (code <= ALG_RC4);
                    if (cur.path_kind == PATH_STD && code < ALG_AES128) ok = 1'b0;
                    if (cur.path_kind == PATH_RC4 && code != ALG_RC4) ok = 1'b0;
                    emit = !(code_ok && ok);
                    nxt.algorithm_code = code;
                end
                POS_HASH_ID: begin
                    ok = (word == 32'd0) || (word == HASHID_SHA1 && !e);
                    if ((cur.path_kind == PATH_STD || cur.path_kind == PATH_RC4) &&
                        word != HASHID_SHA1) ok = 1'b0;
                    if (cur.path_kind == PATH_EXT && word != 32'd0) ok = 1'b0;
                    emit = !ok;
                end
                POS_KEY_SIZE: begin
                    ok = (word[2:0] == 3'd0) &&
                         ((word == 32'd0) ||
                          (cur.algorithm_code == ALG_RC4 &&
                           word >= RC4_KEY_MIN && word <= RC4_KEY_MAX) ||
                          (aes != 9'd0 && word == {23'd0, aes}));
                    if (!c && word != 32'd0) ok = 1'b0;
                    if (cur.path_kind == PATH_STD && (aes == 9'd0 || word != {23'd0, aes}))
                        ok = 1'b0;
                    if (cur.path_kind == PATH_EXT && word != 32'd0) ok = 1'b0;
                    emit = !ok;
                    nxt.saved_aes_key_len = (cur.path_kind == PATH_STD) ? word[8:0] : 9'd0;
                end
                POS_PROVIDER: begin
                    emit = (!c && word != 32'd0) ||
                           (cur.path_kind == PATH_RC4 && word == 32'd0) ||
                           (cur.path_kind == PATH_EXT && word != 32'd0);
                end
                POS_HDR_SIZE, POS_RESERVED1: begin
                    emit = 1'b0;
                end
                POS_RESERVED2: begin
                    emit = 1'b1;
                    if (word != 32'd0) begin
                        verdict.status = ST_BAD_FIELD;
                    end else if (cur.path_kind == PATH_STD) begin
                        verdict.status      = ST_STD_OK;
                        verdict.aes_key_len = cur.saved_aes_key_len;
                    end else if (cur.path_kind == PATH_RC4) begin
                        verdict.status = ST_RC4_API;
                    end else begin
                        verdict.status = ST_EXT;
                    end
                end
                default: begin
                    nxt.verdict_given = 1'b1;
                end
            endcase
            if (emit) nxt.verdict_given = 1'b1;
        end
        state_next = nxt;
    end

endmodule

// ----- rtl/encryption_header_checker.sv -----
// A word accepted into the word register shows its verdict (if any) once it advances.
// Throughput: one header word per cycle unless the result stalls; the word register
//   feeds the rule logic, whose verdict is registered while the next word is taken.
// A header gives at most one verdict, at its deciding word (word 10 at latest).
// Reset (aresetn low, synchronous): both stages empty, checker idle until a word
//   with start_req high arrives; words without start_req are dropped while idle.
module encryption_header_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_word,
    input  logic        s_start_req,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [3:0]  m_fail_index,
    output logic [8:0]  m_aes_key_len
);
    import ehc_pkg::*;

    // Input stage: one word beat waiting to be checked
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [31:0] in_word_reg;
    logic        in_start_reg;

    // Header tracking state
    hdr_state_t  state_reg;
    hdr_state_t  state_next;
    hdr_state_t  chk_state;

    // Result stage
    logic        out_valid_reg;
    logic        out_valid_next;
    verdict_t    out_verdict_reg;

    logic        chk_emit;
    verdict_t    chk_verdict;
    logic        advance;
    logic        s_take;

    ehc_word_check u_check (
        .state      (state_reg),
        .word       (in_word_reg),
        .start_req  (in_start_reg),
        .state_next (chk_state),
        .emit       (chk_emit),
        .verdict    (chk_verdict)
    );

    // Advance the held word whenever the result slot is free or being drained;
    // a word that decides nothing still needs the slot free, keeping order simple.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_take  = s_valid && s_ready;

    always_comb begin
        in_valid_next  = s_take || (in_valid_reg && !advance);
        state_next     = advance ? chk_state : state_reg;
        if (advance) begin
            out_valid_next = chk_emit;
        end else begin
            // Drop the result once the downstream takes it
            out_valid_next = out_valid_reg && !m_ready;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= STATE_IDLE;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers: load on a taken beat / advancing word, else hold
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_word_reg  <= s_word;
            in_start_reg <= s_start_req;
        end
        if (advance && chk_emit) begin
            out_verdict_reg <= chk_verdict;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_verdict_reg.status;
    assign m_fail_index  = out_verdict_reg.fail_index;
    assign m_aes_key_len = out_verdict_reg.aes_key_len;

`ifndef NO_ASSERTIONS
    a_std_key_len : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_STD_OK) |->
        (m_aes_key_len == AES128_BITS || m_aes_key_len == AES192_BITS ||
         m_aes_key_len == AES256_BITS))
        else $error("standard verdict without a valid AES key size");

    a_key_len_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_STD_OK) |-> (m_aes_key_len == 9'd0))
        else $error("key size reported on a non-standard verdict");

    a_agile_index : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_AGILE_OK) |-> (m_fail_index == POS_FLAGS))
        else $error("agile verdict not decided by the flags word");

    a_position_range : assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.verdict_given |-> (state_reg.word_position <= POS_RESERVED2))
        else $error("word position ran past the last header word");

    a_stall_blocks_input : assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready)
        else $error("input taken while both stages are blocked");
`endif

endmodule

// ----- bench/header_verdict_checker.sv -----
// Channel monitor that predicts header verdicts and compares them with the result beats.
`timescale 1ns / 1ps

module header_verdict_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_word,
    input  logic        s_start_req,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [2:0]  m_status,
    input  logic [3:0]  m_fail_index,
    input  logic [8:0]  m_aes_key_len,
    output int          fail_count,
    output int          pending_count
);
    import ehc_pkg::*;

    // Predicted header state
    logic [3:0]  pos_q   = POS_VERSION;
    logic [1:0]  path_q  = PATH_STD;
    logic [31:0] flags_q = '0;
    logic [2:0]  alg_q   = ALG_NONE;
    logic [8:0]  key_q   = '0;
    logic        idle_q  = 1'b1;

    verdict_t pending_verdicts[$];
    verdict_t predicted;
    verdict_t oldest;
    logic     has_verdict;

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t ns] %s: got %0d, predicted %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic logic flags_well_formed(input logic [31:0] fl);
        logic c;
        logic e;
        c = |(fl & FLAG_C);
        e = |(fl & FLAG_E);
        return !(|(fl & FLAG_RSVD_MASK)) && (c != e) &&
               !(e && |(fl & (FLAG_C | FLAG_D | FLAG_F))) &&
               !(|(fl & FLAG_F) && !c);
    endfunction

    // Advance the predicted header by one word; a verdict is returned when this word decides.
    task automatic judge_header_word(input logic [31:0] w, input logic start,
                                     output logic hit, output verdict_t v);
        logic [3:0]  p;
        logic        c;
        logic        e;
        logic        f;
        logic [15:0] major;
        logic [15:0] minor;
        logic [2:0]  code;
        logic [8:0]  aes;
        logic        ok;
        logic        decided;
        logic [2:0]  code_out;
        hit      = 1'b0;
        v        = '0;
        decided  = 1'b0;
        code_out = ST_BAD_FIELD;
        ok       = 1'b1;
        code     = ALG_NONE;
        aes      = '0;
        if (start) begin
            pos_q   = POS_VERSION;
            path_q  = PATH_STD;
            flags_q = '0;
            alg_q   = ALG_NONE;
            key_q   = '0;
            idle_q  = 1'b0;
        end else if (idle_q) begin
            return;
        end
        p     = pos_q;
        pos_q = p + 4'd1;
        c     = |(flags_q & FLAG_C);
        e     = |(flags_q & FLAG_E);
        f     = |(flags_q & FLAG_F);

        case (p)
            POS_VERSION: begin
                major = w[15:0];
                minor = w[31:16];
                if (major == 16'd1 && minor == 16'd1) begin
                    decided  = 1'b1;
                    code_out = ST_RC4;
                end else if (major >= 16'd2 && major <= 16'd4 && minor == 16'd2) begin
                    path_q = PATH_STD;
                end else if ((major == 16'd3 || major == 16'd4) && minor == 16'd3) begin
                    path_q = PATH_EXT;
                end else if (major == 16'd4 && minor == 16'd4) begin
                    path_q = PATH_AGILE;
                end else begin
                    decided  = 1'b1;
                    code_out = ST_BAD_VERSION;
                end
            end
            POS_FLAGS: begin
                if (path_q == PATH_AGILE) begin
                    decided  = 1'b1;
                    code_out = (w == AGILE_FLAGS) ? ST_AGILE_OK : ST_BAD_FIELD;
                end else if (!flags_well_formed(w)) begin
                    decided = 1'b1;
                end else if (path_q == PATH_EXT) begin
                    decided = !(|(w & FLAG_E));
                end else if (|(w & FLAG_E)) begin
                    decided = 1'b1;
                end else if (|(w & FLAG_F)) begin
                    if (|(w & FLAG_D)) decided = 1'b1;
                    else path_q = PATH_STD;
                end else begin
                    path_q = PATH_RC4;
                end
                if (decided && path_q != PATH_AGILE) code_out = ST_BAD_FLAGS;
                if (!decided) flags_q = w;
            end
            POS_FLAGS_CPY: begin
                if (!flags_well_formed(w) || w != flags_q) begin
                    decided  = 1'b1;
                    code_out = ST_BAD_FLAGS;
                end
            end
            POS_EXTRA: decided = (w != 32'd0);
            POS_ALG_ID: begin
                if      (w == 32'd0)        code = ALG_NONE;
                else if (w == ALGID_RC4)    code = ALG_RC4;
                else if (w == ALGID_AES128) code = ALG_AES128;
                else if (w == ALGID_AES192) code = ALG_AES192;
                else if (w == ALGID_AES256) code = ALG_AES256;
                else                        ok = 1'b0;
                if (ok) begin
                    if (e)      ok = (code == ALG_NONE);
                    else if (f) ok = (code == ALG_NONE) || (code >= ALG_AES128);
                    else        ok = (code <= ALG_RC4);
                    if (path_q == PATH_STD && code < ALG_AES128) ok = 1'b0;
                    if (path_q == PATH_RC4 && code != ALG_RC4) ok = 1'b0;
                end
                decided = !ok;
                if (ok) alg_q = code;
            end
            POS_HASH_ID: begin
                ok = (w == 32'd0) || (w == HASHID_SHA1 && !e);
                if ((path_q == PATH_STD || path_q == PATH_RC4) && w != HASHID_SHA1) ok = 1'b0;
                if (path_q == PATH_EXT && w != 32'd0) ok = 1'b0;
                decided = !ok;
            end
            POS_KEY_SIZE: begin
                case (alg_q)
                    ALG_AES128: aes = AES128_BITS;
                    ALG_AES192: aes = AES192_BITS;
                    ALG_AES256: aes = AES256_BITS;
                    default:    aes = 9'd0;
                endcase
                ok = (w[2:0] == 3'd0) &&
                     (w == 32'd0 ||
                      (alg_q == ALG_RC4 && w >= RC4_KEY_MIN && w <= RC4_KEY_MAX) ||
                      (aes != 9'd0 && w == 32'(aes)));
                if (!c && w != 32'd0) ok = 1'b0;
                if (path_q == PATH_STD && (aes == 9'd0 || w != 32'(aes))) ok = 1'b0;
                if (path_q == PATH_EXT && w != 32'd0) ok = 1'b0;
                decided = !ok;
                if (ok) key_q = (path_q == PATH_STD) ? w[8:0] : 9'd0;
            end
            POS_PROVIDER: begin
                decided = (!c && w != 32'd0) || (path_q == PATH_RC4 && w == 32'd0) ||
                          (path_q == PATH_EXT && w != 32'd0);
            end
            POS_HDR_SIZE, POS_RESERVED1: ;
            POS_RESERVED2: begin
                decided = 1'b1;
                if (w != 32'd0)            code_out = ST_BAD_FIELD;
                else if (path_q == PATH_STD) code_out = ST_STD_OK;
                else if (path_q == PATH_RC4) code_out = ST_RC4_API;
                else                         code_out = ST_EXT;
            end
            default: idle_q = 1'b1;
        endcase

        if (decided) begin
            hit           = 1'b1;
            v.status      = code_out;
            v.fail_index  = p;
            v.aes_key_len = (code_out == ST_STD_OK) ? key_q : 9'd0;
            idle_q        = 1'b1;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                judge_header_word(s_word, s_start_req, has_verdict, predicted);
                if (has_verdict) pending_verdicts.push_back(predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("verdict beat with none pending, status",
                                    int'(m_status), 0);
                end else begin
                    oldest = pending_verdicts.pop_front();
                    if (m_status !== oldest.status)
                        report_mismatch("status", int'(m_status), int'(oldest.status));
                    if (m_fail_index !== oldest.fail_index)
                        report_mismatch("fail_index", int'(m_fail_index),
                                        int'(oldest.fail_index));
                    if (m_aes_key_len !== oldest.aes_key_len)
                        report_mismatch("aes_key_len", int'(m_aes_key_len),
                                        int'(oldest.aes_key_len));
                end
            end
            pending_count = pending_verdicts.size();
        end
    end

endmodule

// ----- bench/tb_top.sv -----
// Top of the header checker bench: clock, reset, header stimulus and the final verdict.
`timescale 1ns / 1ps

module tb_top;
    import ehc_pkg::*;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic [31:0] s_word      = '0;
    logic        s_start_req = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic [2:0]  m_status;
    logic [3:0]  m_fail_index;
    logic [8:0]  m_aes_key_len;

    int fail_count;
    int pending_count;

    // Idle odds in percent for each side, changed per phase
    int send_idle = 0;
    int recv_idle = 0;
    int words_sent = 0;

    always #6 aclk = ~aclk;

    encryption_header_checker DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word        (s_word),
        .s_start_req   (s_start_req),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_fail_index  (m_fail_index),
        .m_aes_key_len (m_aes_key_len)
    );

    header_verdict_checker CHK (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word        (s_word),
        .s_start_req   (s_start_req),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_fail_index  (m_fail_index),
        .m_aes_key_len (m_aes_key_len),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    // Stall the verdict channel at random; ready may drop at any cycle.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // Drive one word beat. Enter and leave at a falling edge; valid stays high into the
    // next beat when no gap is drawn, so it is never lowered and raised in one step.
    task automatic send_beat(input logic [31:0] w, input logic start);
        while ($urandom_range(99) < send_idle) begin
            s_valid     <= 1'b0;
            s_word      <= $urandom;
            s_start_req <= 1'($urandom_range(1));
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_word      <= w;
        s_start_req <= start;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        words_sent++;
    endtask

    // Build one header, mostly well formed, then damage, cut short or trail it with noise.
    task automatic random_header();
        logic [31:0] h [11];
        logic [15:0] major;
        int          kind;
        int          n;
        int          spot;
        int          extra;
        kind  = $urandom_range(99);
        major = 16'($urandom_range(4, 2));
        n     = 11;
        h[0]  = '0;
        h[1]  = '0;
        h[2]  = $urandom;
        h[3]  = '0;
        h[4]  = '0;
        h[5]  = '0;
        h[6]  = '0;
        h[7]  = '0;
        h[8]  = '0;
        h[9]  = $urandom;
        h[10] = '0;
        if (kind < 35) begin
            // standard AES path
            h[0] = {16'd2, major};
            h[1] = FLAG_C | FLAG_F;
            h[6] = HASHID_SHA1;
            h[8] = $urandom;
            case ($urandom_range(2))
                0:       begin h[5] = ALGID_AES128; h[7] = 32'(AES128_BITS); end
                1:       begin h[5] = ALGID_AES192; h[7] = 32'(AES192_BITS); end
                default: begin h[5] = ALGID_AES256; h[7] = 32'(AES256_BITS); end
            endcase
        end else if (kind < 60) begin
            // RC4 with the API flag, doc props optional
            h[0] = {16'd2, major};
            h[1] = FLAG_C | ($urandom_range(1) ? FLAG_D : 32'd0);
            h[5] = ALGID_RC4;
            h[6] = HASHID_SHA1;
            h[7] = ($urandom_range(3) == 0) ? 32'd0 : 32'($urandom_range(16, 5) * 8);
            h[8] = $urandom | 32'd1;
        end else if (kind < 80) begin
            // extensible path, every optional field zero
            h[0] = {16'd3, 16'($urandom_range(4, 3))};
            h[1] = FLAG_E;
        end else if (kind < 88) begin
            h[0] = {16'd4, 16'd4};
            h[1] = AGILE_FLAGS;
            n    = 2;
        end else if (kind < 93) begin
            h[0] = {16'd1, 16'd1};
            n    = 1;
        end else begin
            // raw noise behind a random version word
            foreach (h[i]) h[i] = $urandom;
            n = $urandom_range(11, 1);
        end
        h[3] = h[1];

        // Damage one word: flip a bit, use a small value, or replace it outright.
        if ($urandom_range(99) < 40) begin
            spot = $urandom_range(n - 1);
            case ($urandom_range(2))
                0:       h[spot] = h[spot] ^ (32'd1 << $urandom_range(31));
                1:       h[spot] = 32'($urandom_range(64));
                default: h[spot] = $urandom;
            endcase
        end
        // Cut short so the next start drops the header in progress.
        if ($urandom_range(99) < 10) n = $urandom_range(n, 1);

        for (int i = 0; i < n; i++) send_beat(h[i], (i == 0));

        // Trail with words that carry no start.
        if ($urandom_range(99) < 10) begin
            extra = $urandom_range(3, 1);
            for (int i = 0; i < extra; i++) send_beat($urandom, 1'b0);
        end
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle = 37;
        recv_idle = 55;

        // Directed headers
        send_beat(32'h0000_1234, 1'b0);          // word with no start while idle: drop it
        send_beat({16'd1, 16'd1}, 1'b1);         // old stream-cipher scheme
        send_beat(32'hFFFF_FFFF, 1'b1);          // bad version, all ones
        send_beat(32'h0000_0000, 1'b1);          // bad version, all zeros
        send_beat({16'd4, 16'd4}, 1'b1);         // agile, good flags word
        send_beat(AGILE_FLAGS, 1'b0);
        send_beat({16'd4, 16'd4}, 1'b1);         // agile, wrong flags word
        send_beat(32'hFFFF_FFFF, 1'b0);
        send_beat({16'd3, 16'd3}, 1'b1);         // extensible version with API flag
        send_beat(FLAG_C, 1'b0);
        send_beat({16'd2, 16'd3}, 1'b1);         // start while busy: abandon this one
        send_beat(FLAG_C | FLAG_F, 1'b0);
        send_beat({16'd2, 16'd4}, 1'b1);         // full standard AES-256 header
        send_beat(FLAG_C | FLAG_F, 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b0);          // header size: any value
        send_beat(FLAG_C | FLAG_F, 1'b0);
        send_beat(32'd0, 1'b0);
        send_beat(ALGID_AES256, 1'b0);
        send_beat(HASHID_SHA1, 1'b0);
        send_beat(32'(AES256_BITS), 1'b0);
        send_beat(32'hFFFF_FFFF, 1'b0);          // provider
        send_beat(32'h0000_0000, 1'b0);          // reserved1
        send_beat(32'd0, 1'b0);                  // reserved2

        // Random headers in three idling phases
        while (words_sent < 340) random_header();
        send_idle = 55;
        recv_idle = 37;
        while (words_sent < 680) random_header();
        send_idle = 0;
        recv_idle = 0;
        while (words_sent < 1020) random_header();
        s_valid <= 1'b0;

        // Drain outstanding verdicts, then keep watching for stray beats.
        while (pending_count != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);

        if (fail_count == 0 && pending_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Hard stop if the handshakes hang
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
